FILE: hw/rtl/sbtf_pkg.sv
// ----------------------------------------------------------------------------
// sbtf_pkg: shared definitions for the spectrum bin telemetry framer
// Channel and frame geometry, header byte codes, controller states and the
// helper functions that build the fixed part of each telemetry frame.
// ----------------------------------------------------------------------------
package sbtf_pkg;

	// histogram geometry
	localparam int NUM_CHANNELS  = 1024;
	localparam int FRAME_BYTES   = 128;
	localparam int BEAT_BYTES    = 16;
	localparam int HDR_BYTES     = 9;
	localparam int DATA_BYTES    = 119;
	localparam int MAX_FRAMES    = 5;
	localparam int SPEC_BYTES    = (NUM_CHANNELS + 1) / 2;
	localparam int FRAMES_NEEDED = (SPEC_BYTES + DATA_BYTES - 1) / DATA_BYTES;
	localparam int NUM_FRAMES    = (FRAMES_NEEDED > MAX_FRAMES) ? MAX_FRAMES : FRAMES_NEEDED;
	localparam int SENT_BYTES    = (SPEC_BYTES < NUM_FRAMES * DATA_BYTES) ?
		SPEC_BYTES : NUM_FRAMES * DATA_BYTES;
	localparam int LAST_USED     = SENT_BYTES - (NUM_FRAMES - 1) * DATA_BYTES;
	localparam int ADDR_W        = (SPEC_BYTES > 1) ? $clog2(SPEC_BYTES) : 1;
	localparam int POS_W         = $clog2(FRAME_BYTES);
	localparam bit NEED_SWEEP    = (SPEC_BYTES > SENT_BYTES);

	// port widths
	localparam int TIME_W      = 48;
	localparam int PH_W        = 12;
	localparam int FIDX_W      = 3;
	localparam int CFG_W       = 32;
	localparam int S_TDATA_W   = 64;
	localparam int M_TDATA_W   = 136;
	localparam int BEAT_W      = 8 * BEAT_BYTES;

	// reset values
	localparam logic [CFG_W-1:0] BIN_LENGTH_RST = 32'd1000000;
	localparam logic [31:0]      BIN_NUMBER_RST = 32'd1;

	// frame header codes
	localparam logic [7:0] SYNC_0     = 8'h4B;
	localparam logic [7:0] SYNC_1     = 8'h82;
	localparam logic [7:0] FRAME_TYPE = 8'h83;
	localparam logic [3:0] COUNT_MAX  = 4'hF;

	// header byte positions
	localparam logic [POS_W-1:0] POS_SYNC_0 = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC_1 = POS_W'(1);
	localparam logic [POS_W-1:0] POS_BIN_3  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_BIN_2  = POS_W'(3);
	localparam logic [POS_W-1:0] POS_BIN_1  = POS_W'(4);
	localparam logic [POS_W-1:0] POS_BIN_0  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_FIDX   = POS_W'(6);
	localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(7);
	localparam logic [POS_W-1:0] POS_USED   = POS_W'(8);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_DUMP,
		ST_BEAT,
		ST_READ,
		ST_WRITE
	} sbtf_state_t;

	// payload bytes carried by a frame
	function automatic logic [7:0] used_bytes(input logic [FIDX_W-1:0] frame);
		logic [7:0] used;
		used = (frame == FIDX_W'(NUM_FRAMES - 1)) ? 8'(LAST_USED) : 8'(DATA_BYTES);
		return used;
	endfunction

	// fixed header content, zero elsewhere
	function automatic logic [7:0] hdr_byte(
		input logic [POS_W-1:0]  pos,
		input logic [FIDX_W-1:0] frame,
		input logic [31:0]       bin_num
	);
		logic [7:0] b;
		case (pos)
			POS_SYNC_0: b = SYNC_0;
			POS_SYNC_1: b = SYNC_1;
			POS_BIN_3:  b = bin_num[31:24];
			POS_BIN_2:  b = bin_num[23:16];
			POS_BIN_1:  b = bin_num[15:8];
			POS_BIN_0:  b = bin_num[7:0];
			POS_FIDX:   b = {{(8 - FIDX_W){1'b0}}, frame};
			POS_TYPE:   b = FRAME_TYPE;
			POS_USED:   b = used_bytes(frame);
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

FILE: hw/rtl/sbtf_ram.sv
// ----------------------------------------------------------------------------
// sbtf_ram: generic single-clock ram
// One write port and one read port, read data registered, read-first when
// both ports hit the same address.
// ----------------------------------------------------------------------------
module sbtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/spectrum_bin_telemetry_framer.sv
// ----------------------------------------------------------------------------
// spectrum_bin_telemetry_framer: photon histogram with telemetry frame dump
// Counts photon events into a 4-bit-per-channel histogram and dumps it as
// 128-byte telemetry frames when an event arrives past the current bin end.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel carries events (time, pulse height); m_* channel carries the
//  dump as 16-byte beats, tlast on the last beat of each frame and tuser on the
//  last beat of the dump. cfg_we/cfg_wdata load the bin length, which also
//  reloads the bin end and sets the bin number back to one.
//  The histogram lives in a 512 x 8 ram, two channels per byte, and every
//  access goes through its one read and one write port under a small
//  sequencer. An event with no dump passes through accept, compare, read and
//  write back; one with a pulse height out of range ends after the compare.
//  A dump issues one frame byte per cycle and closes each beat in a beat
//  state that waits for the output register; the 40 beats are followed by the
//  count of the event. Bytes are cleared as they are read out.
//  After reset the ram is swept to zero, one byte a cycle, with s_tready
//  low. A beat waits in the output register while m_tready is low;
//  the sequencer then holds on the next finished beat, input stays blocked.
// ----------------------------------------------------------------------------
module spectrum_bin_telemetry_framer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbtf_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// event_time, pulse_height, zero pad
	input  logic [sbtf_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// frame_index, beat_index, data_high, data_low, zero pad
	output logic [sbtf_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	// dump_end
	output logic                           m_tuser
);

	import sbtf_pkg::*;

	sbtf_state_t state_q, state_d;

	logic [TIME_W-1:0] time_q;
	logic [PH_W-1:0]   ph_q;
	logic [CFG_W-1:0]  bin_len_q;
	logic [TIME_W-1:0] bin_end_q;
	logic [31:0]       bin_num_q;
	logic [POS_W-1:0]  pos_q;
	logic [FIDX_W-1:0] frame_q;
	logic [ADDR_W-1:0] addr_q;
	logic              pend_q;

	logic              is_data_s1;
	logic [7:0]        hdr_s1;
	logic [BEAT_W-9:0] beat_q;

	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic              m_tlast_q;
	logic              m_tuser_q;

	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;

	logic [PH_W-1:0]   ch;
	logic [ADDR_W-1:0] cnt_addr;
	logic              ph_ok;
	logic              dump_due;
	logic [7:0]        used;
	logic              data_here;
	logic [7:0]        cur_byte;
	logic [BEAT_W-1:0] beat_full;
	logic              out_free;
	logic              last_pos;
	logic              last_frame;
	logic              clear_last;
	logic              dump_done;
	logic [3:0]        nib_old, nib_new;
	logic [7:0]        cnt_byte;

	// event decode
	assign ch       = ph_q - PH_W'(1);
	assign cnt_addr = ADDR_W'(ch >> 1);
	assign ph_ok    = (ph_q != '0) && (ph_q <= PH_W'(NUM_CHANNELS));
	assign dump_due = time_q > bin_end_q;

	// frame position decode
	assign used       = used_bytes(frame_q);
	assign data_here  = ({1'b0, pos_q} >= 8'(HDR_BYTES)) &&
		({1'b0, pos_q} < (8'(HDR_BYTES) + used));
	assign cur_byte   = is_data_s1 ? ram_rdata : hdr_s1;
	assign beat_full  = {beat_q, cur_byte};
	assign out_free   = !m_tvalid_q || m_tready;
	assign last_pos   = pos_q == POS_W'(FRAME_BYTES - 1);
	assign last_frame = frame_q == FIDX_W'(NUM_FRAMES - 1);
	assign clear_last = addr_q == ADDR_W'(SPEC_BYTES - 1);
	assign dump_done  = (state_q == ST_BEAT) && out_free && last_pos && last_frame;

	// saturating nibble increment, even channel in the high nibble
	assign nib_old  = ch[0] ? ram_rdata[3:0] : ram_rdata[7:4];
	assign nib_new  = (nib_old == COUNT_MAX) ? nib_old : nib_old + 4'd1;
	assign cnt_byte = ch[0] ? {ram_rdata[7:4], nib_new} : {nib_new, ram_rdata[3:0]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clear_last) begin
					state_d = (pend_q && ph_ok) ? ST_READ : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (dump_due) begin
					state_d = ST_DUMP;
				end else if (ph_ok) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (pos_q[3:0] == 4'hF) begin
					state_d = ST_BEAT;
				end
			end
			ST_BEAT: begin
				if (out_free) begin
					if (last_pos && last_frame) begin
						if (NEED_SWEEP) begin
							state_d = ST_CLEAR;
						end else begin
							state_d = ph_ok ? ST_READ : ST_IDLE;
						end
					end else begin
						state_d = ST_DUMP;
					end
				end
			end
			ST_READ:  state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: ram ports and input ready
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = 8'h00;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_DUMP: begin
				ram_we = data_here;
				ram_re = data_here;
			end
			ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = cnt_addr;
			end
			ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_addr;
				ram_wdata = cnt_byte;
			end
			default: begin
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// ram address, frame position and pending event flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			pos_q   <= '0;
			frame_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (clear_last) begin
						pend_q <= 1'b0;
					end
				end
				ST_CHECK: begin
					addr_q  <= '0;
					pos_q   <= '0;
					frame_q <= '0;
					pend_q  <= dump_due;
				end
				ST_DUMP: begin
					if (data_here) begin
						addr_q <= addr_q + ADDR_W'(1);
					end
					if (pos_q[3:0] != 4'hF) begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				ST_BEAT: begin
					if (out_free) begin
						pos_q <= pos_q + POS_W'(1);
						if (last_pos) begin
							frame_q <= last_frame ? '0 : frame_q + FIDX_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// bin length, bin end and bin number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_len_q <= BIN_LENGTH_RST;
			bin_end_q <= TIME_W'(BIN_LENGTH_RST);
			bin_num_q <= BIN_NUMBER_RST;
		end else if (cfg_we) begin
			bin_len_q <= cfg_wdata;
			bin_end_q <= TIME_W'(cfg_wdata);
			bin_num_q <= BIN_NUMBER_RST;
		end else if (dump_done) begin
			bin_end_q <= bin_end_q + TIME_W'(bin_len_q);
			bin_num_q <= bin_num_q + 32'd1;
		end
	end

	// event capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			time_q <= s_tdata[TIME_W-1:0];
			ph_q   <= s_tdata[TIME_W+PH_W-1:TIME_W];
		end
	end

	// byte issue stage and beat assembly
	always_ff @(posedge clk) begin
		if (state_q == ST_DUMP) begin
			is_data_s1 <= data_here;
			hdr_s1     <= hdr_byte(pos_q, frame_q, bin_num_q);
			if (pos_q[3:0] != 4'h0) begin
				beat_q <= beat_full[BEAT_W-9:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_BEAT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_BEAT) && out_free) begin
			m_tdata_q <= {2'b00, beat_full[63:0], beat_full[127:64], pos_q[6:4], frame_q};
			m_tlast_q <= last_pos;
			m_tuser_q <= last_pos && last_frame;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// histogram store, two channels per byte
	sbtf_ram #(
		.WIDTH (8),
		.DEPTH (SPEC_BYTES),
		.AW    (ADDR_W)
	) u_hist_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// end of dump only ever on a frame's last beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("dump end flagged off a frame boundary");

	// frame end marks exactly beat seven
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[5:3] == 3'd7)))
		else $error("frame end does not match beat index");

	// frame index stays within the dump
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= 3'(NUM_FRAMES - 1)))
		else $error("frame index beyond last frame");

	// no event taken while a dump is under way
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP || state_q == ST_BEAT) |-> !s_tready)
		else $error("input ready during dump");

endmodule
